>>> design/assert_macros.svh
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define GMF_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

`define GMF_ASSERT_NEVER(lbl, ck, rs, expr, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) !(expr)) else $error(msg);

`else

`define GMF_ASSERT(lbl, ck, rs, prop, msg)

`define GMF_ASSERT_NEVER(lbl, ck, rs, expr, msg)

`endif

`endif

>>> design/gmf_pkg.sv
package gmf_pkg;

  localparam int PIX_W        = 8;
  localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;
  localparam int COORD_W      = 11;
  localparam int RAD_W        = 2;
  localparam int RAD_EFF_W    = 3;
  localparam int CFG_DIM_W    = 12;
  localparam int CFG_DATA_W   = 12;
  localparam int REG_IDX_W    = 3;
  localparam int SLOT_FIELD_W = 4;
  localparam int ADDR_FIELD_W = 13;
  localparam int IN_TDATA_W   = 8;
  localparam int OUT_TDATA_W  = 32;
  localparam int OUT_PAD_W    = OUT_TDATA_W - PIX_W - 2 * COORD_W;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W        = QPTR_W + 1;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_OPERATION    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_SHAPE = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RADIUS       = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd4;

  localparam logic OP_ERODE     = 1'b0;
  localparam logic OP_DILATE    = 1'b1;
  localparam logic SHAPE_CROSS  = 1'b0;
  localparam logic SHAPE_SQUARE = 1'b1;

  typedef struct packed {
    logic                 operation;
    logic                 window_shape;
    logic [RAD_W-1:0]     radius;
    logic [CFG_DIM_W-1:0] frame_width;
    logic [CFG_DIM_W-1:0] frame_height;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    operation:    OP_ERODE,
    window_shape: SHAPE_SQUARE,
    radius:       2'd1,
    frame_width:  12'd640,
    frame_height: 12'd480
  };

  // one classified pixel on its way from the front to the back
  typedef struct packed {
    logic [PIX_W-1:0]        pixel;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [ADDR_FIELD_W-1:0] col;
    logic                    emit;
    logic [COORD_W-1:0]      centre_row;
    logic [COORD_W-1:0]      centre_col;
    logic                    last;
  } item_t;

  function automatic logic [RAD_EFF_W-1:0] radius_eff(logic [RAD_W-1:0] r,
                                                      logic [RAD_EFF_W-1:0] max_r);
    logic [RAD_EFF_W-1:0] rx;
    rx = RAD_EFF_W'(r);
    return (rx > max_r) ? max_r : rx;
  endfunction

  function automatic logic [PIX_W-1:0] fold_pix(logic [PIX_W-1:0] acc,
                                                logic [PIX_W-1:0] p, logic dil);
    if (dil == OP_DILATE) return (p > acc) ? p : acc;
    return (p < acc) ? p : acc;
  endfunction

endpackage

>>> design/gmf_front.sv
`include "assert_macros.svh"

module gmf_front import gmf_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048,
  parameter int MAX_RADIUS = 3
) (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [PIX_W-1:0] pixel,
  output item_t            item
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int SLOTS = 2 * MAX_RADIUS + 1;
  localparam int SW    = $clog2(SLOTS);
  localparam int EW    = (CFG_DIM_W > CW + 1) ? CFG_DIM_W : CW + 1;
  localparam int EH    = (CFG_DIM_W > RW + 1) ? CFG_DIM_W : RW + 1;

  logic [CW-1:0]        col;
  logic [RW-1:0]        row;
  logic [SW-1:0]        slot;
  logic                 accept;
  logic [RAD_EFF_W-1:0] m;
  logic [EW-1:0]        fw, w, cx, two_mw;
  logic [EH-1:0]        fh, h, rx, two_mh;
  logic                 at_row_end, at_frame_end;
  logic [RW-1:0]        crow;
  logic [CW-1:0]        ccol;

  assign accept = in_valid && in_ready;

  // effective frame size: zero reads as one, oversize saturates
  assign m  = radius_eff(cfg.radius, RAD_EFF_W'(MAX_RADIUS));
  assign fw = EW'(cfg.frame_width);
  assign fh = EH'(cfg.frame_height);
  assign w  = (fw == '0) ? EW'(1) : ((fw > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : fw);
  assign h  = (fh == '0) ? EH'(1) : ((fh > EH'(MAX_HEIGHT)) ? EH'(MAX_HEIGHT) : fh);
  assign cx = EW'(col);
  assign rx = EH'(row);
  assign two_mw = EW'(m) << 1;
  assign two_mh = EH'(m) << 1;

  assign at_row_end   = cx >= w - 1'b1;
  assign at_frame_end = rx >= h - 1'b1;
  assign crow = row - RW'(m);
  assign ccol = col - CW'(m);

  assign item.pixel      = pixel;
  assign item.slot       = SLOT_FIELD_W'(slot);
  assign item.col        = ADDR_FIELD_W'(col);
  assign item.emit       = (rx < h) && (cx < w) && (rx >= two_mh) && (cx >= two_mw);
  assign item.centre_row = COORD_W'(crow);
  assign item.centre_col = COORD_W'(ccol);
  assign item.last       = (rx == h - 1'b1) && (cx == w - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      slot <= '0;
    end else if (accept) begin
      if (at_row_end) begin
        col <= '0;
        if (at_frame_end) begin
          row  <= '0;
          slot <= '0;
        end else begin
          row  <= row + 1'b1;
          slot <= (slot == SW'(SLOTS - 1)) ? '0 : slot + 1'b1;
        end
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  `GMF_ASSERT(a_slot_range, clk, rst, slot <= SW'(SLOTS - 1), "line slot out of range")
  `GMF_ASSERT(a_slot_row0, clk, rst, (row == '0) |-> (slot == '0), "slot not aligned to row")

endmodule

>>> design/gmf_queue.sv
`include "assert_macros.svh"

module gmf_queue import gmf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  pop_ready,
  output item_t out_item
);

  item_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              pop;

  assign in_ready  = count != CNT_W'(QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign pop       = out_valid && pop_ready;
  assign out_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_item;
  end

  `GMF_ASSERT_NEVER(a_no_overrun, clk, rst, push && (count == CNT_W'(QUEUE_DEPTH)), "push into full queue")
  `GMF_ASSERT(a_count_bound, clk, rst, count <= CNT_W'(QUEUE_DEPTH), "queue count overflow")

endmodule

>>> design/gmf_back.sv
`include "assert_macros.svh"

module gmf_back import gmf_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_RADIUS = 3
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_t                   cfg,
  input  logic                   q_valid,
  input  item_t                  q_item,
  output logic                   q_ready,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tlast
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int SLOTS = 2 * MAX_RADIUS + 1;
  localparam int SW    = $clog2(SLOTS);

  logic                 adv, pop;
  logic                 out_valid;
  logic [PIX_W-1:0]     rd_data [SLOTS];
  logic [CW-1:0]        addr;

  logic                 v1, v2, v3;
  item_t                it1, it2, it3;
  logic [SW-1:0]        slot1, idx;
  logic [PIX_W-1:0]     newcol [SLOTS];
  logic [PIX_W-1:0]     win [SLOTS][SLOTS];
  logic [PIX_W-1:0]     row_red [SLOTS];
  logic [PIX_W-1:0]     row_red_next [SLOTS];

  logic [RAD_EFF_W-1:0] m;
  int                   mi;
  logic                 dil, incl;
  logic [PIX_W-1:0]     ident, acc, acc_out;

  logic [PIX_W-1:0]     out_pix;
  logic [COORD_W-1:0]   out_row, out_col;
  logic                 out_last;

  // the whole back end moves together whenever the output register can take a beat
  assign adv     = !out_valid || m_tready;
  assign pop     = adv && q_valid;
  assign q_ready = adv;
  assign addr    = q_item.col[CW-1:0];

  // one line bank per row slot: write the new pixel, read the column above it
  for (genvar s = 0; s < SLOTS; s++) begin : g_bank
    logic [PIX_W-1:0] bank [MAX_WIDTH];
    logic [PIX_W-1:0] rd_q;
    always_ff @(posedge clk) begin
      if (pop) begin
        if (q_item.slot[SW-1:0] == SW'(s)) bank[addr] <= q_item.pixel;
        rd_q <= bank[addr];
      end
    end
    assign rd_data[s] = rd_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= q_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) it1 <= q_item;
  end

  // row dr of the new column is row r-dr, found in slot (slot - dr) mod slots
  assign slot1 = it1.slot[SW-1:0];
  always_comb begin
    newcol[0] = it1.pixel;
    idx = '0;
    for (int dr = 1; dr < SLOTS; dr++) begin
      if (slot1 >= SW'(dr)) idx = slot1 - SW'(dr);
      else idx = slot1 + SW'(SLOTS - dr);
      newcol[dr] = rd_data[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v1) begin
      it2 <= it1;
      for (int dr = 0; dr < SLOTS; dr++) begin
        win[dr][0] <= newcol[dr];
        for (int dc = 1; dc < SLOTS; dc++) begin
          win[dr][dc] <= win[dr][dc-1];
        end
      end
    end
  end

  assign m     = radius_eff(cfg.radius, RAD_EFF_W'(MAX_RADIUS));
  assign dil   = cfg.operation;
  assign ident = (dil == OP_DILATE) ? '0 : PIX_MAX;

  // per-row reduction, taps outside the window shape read as the identity
  always_comb begin
    mi   = int'(m);
    incl = 1'b0;
    acc  = ident;
    for (int dr = 0; dr < SLOTS; dr++) begin
      acc = ident;
      for (int dc = 0; dc < SLOTS; dc++) begin
        if (cfg.window_shape == SHAPE_SQUARE) begin
          incl = (dr <= 2 * mi) && (dc <= 2 * mi);
        end else begin
          incl = ((dc == mi) && (dr <= 2 * mi)) || ((dr == mi) && (dc <= 2 * mi));
        end
        if (incl) acc = fold_pix(acc, win[dr][dc], dil);
      end
      row_red_next[dr] = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v2) begin
      it3 <= it2;
      row_red <= row_red_next;
    end
  end

  always_comb begin
    acc_out = ident;
    for (int dr = 0; dr < SLOTS; dr++) begin
      acc_out = fold_pix(acc_out, row_red[dr], dil);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v3 && it3.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v3) begin
      out_pix  <= acc_out;
      out_row  <= it3.centre_row;
      out_col  <= it3.centre_col;
      out_last <= it3.last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_col, out_row, out_pix};
  assign m_tlast  = out_last;

  `GMF_ASSERT(a_out_from_emit, clk, rst, $rose(out_valid) |-> $past(v3 && it3.emit), "result without interior centre")
  `GMF_ASSERT(a_stage_slot, clk, rst, v1 |-> (it1.slot < SLOT_FIELD_W'(SLOTS)), "bad slot in window stage")

endmodule

>>> design/grayscale_morphology_filter_top.sv
// each pixel passes the queue, bank read, window taps, row reductions and output register
// throughput: one pixel per clock unless stalled; one column read per line bank per pixel
// a four-entry queue parts pixel intake from the window pipeline, so either side may stall
// reset (rst, synchronous, active high) clears the counters, queue, stage valids and registers
// line banks and window taps are not cleared; no clearing pass, the block is ready at once
module grayscale_morphology_filter_top import gmf_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048,
  parameter int MAX_RADIUS = 3
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] pixel_in
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [7:0] pixel_out, [18:8] centre_row,
                                            // [29:19] centre_col, [31:30] zero
  output logic                   m_tlast,   // last_pixel
  input  logic                   cfg_we,
  input  logic [REG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t  cfg;
  item_t front_item, head_item;
  logic  q_in_ready, q_out_valid, q_out_ready, push;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OPERATION:    cfg.operation    <= cfg_data[0];
        REG_WINDOW_SHAPE: cfg.window_shape <= cfg_data[0];
        REG_RADIUS:       cfg.radius       <= cfg_data[RAD_W-1:0];
        REG_FRAME_WIDTH:  cfg.frame_width  <= cfg_data[CFG_DIM_W-1:0];
        REG_FRAME_HEIGHT: cfg.frame_height <= cfg_data[CFG_DIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_tready = q_in_ready;
  assign push     = s_tvalid && q_in_ready;

  gmf_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (q_in_ready),
    .pixel    (s_tdata[PIX_W-1:0]),
    .item     (front_item)
  );

  gmf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .in_ready  (q_in_ready),
    .out_valid (q_out_valid),
    .pop_ready (q_out_ready),
    .out_item  (head_item)
  );

  gmf_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_out_valid),
    .q_item   (head_item),
    .q_ready  (q_out_ready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

>>> test/grayscale_morphology_filter_top_tb.sv
module grayscale_morphology_filter_top_tb;
  import gmf_pkg::*;

  localparam int SLOTS         = 7;
  localparam int COLS_CAP      = 2048;
  localparam int ROWS_CAP      = 2048;
  localparam int RANDOM_BEATS  = 340;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_LIMIT    = 2000;
  localparam int PRINT_CAP     = 30;

  typedef struct {
    logic [PIX_W-1:0]   value;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               tail;
  } morph_beat_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;
  logic                   cfg_we = 1'b0;
  logic [REG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  grayscale_morphology_filter_top uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // shadow of the block: registers, line store and raster counters
  cfg_t              shadow_cfg = CFG_RESET;
  logic [PIX_W-1:0]  line_mem [SLOTS][COLS_CAP];
  int unsigned       pix_row = 0;
  int unsigned       pix_col = 0;

  logic [PIX_W-1:0]  pixels_to_send [$];
  morph_beat_t       expected_morph [$];

  int send_wait = 0;
  bit send_burst = 1'b0;
  int recv_wait = 0;
  int recv_hold = 0;
  bit recv_burst = 1'b0;
  int hold_requests = 0;
  int holds_done = 0;
  int idle_cycles = 0;

  int mismatch_count = 0;
  int beats_in = 0;
  int beats_out = 0;
  int pixels_queued = 0;
  int settings_used = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int unsigned dim_eff(int unsigned v, int unsigned cap);
    if (v == 0) return 1;
    return (v > cap) ? cap : v;
  endfunction

  function automatic logic [PIX_W-1:0] extreme_of(logic [PIX_W-1:0] acc, logic [PIX_W-1:0] p);
    if (shadow_cfg.operation == OP_DILATE) return (p > acc) ? p : acc;
    return (p < acc) ? p : acc;
  endfunction

  // store one accepted pixel, work out its window result if it has one, step the raster
  function automatic void absorb_pixel(logic [PIX_W-1:0] px);
    int unsigned w, h, m, r, c, k, l;
    logic [PIX_W-1:0] acc;
    morph_beat_t res;
    w = dim_eff(shadow_cfg.frame_width, COLS_CAP);
    h = dim_eff(shadow_cfg.frame_height, ROWS_CAP);
    m = shadow_cfg.radius;
    r = pix_row;
    c = pix_col;
    line_mem[r % SLOTS][c % COLS_CAP] = px;
    if (r < h && c < w && r >= 2 * m && c >= 2 * m) begin
      acc = (shadow_cfg.operation == OP_DILATE) ? '0 : '1;
      if (shadow_cfg.window_shape == SHAPE_SQUARE) begin
        for (k = 0; k <= 2 * m; k++)
          for (l = 0; l <= 2 * m; l++)
            acc = extreme_of(acc,
                             line_mem[(r - 2 * m + k) % SLOTS][(c - 2 * m + l) % COLS_CAP]);
      end else begin
        for (k = 0; k <= 2 * m; k++)
          acc = extreme_of(acc, line_mem[(r - 2 * m + k) % SLOTS][(c - m) % COLS_CAP]);
        for (l = 0; l <= 2 * m; l++)
          acc = extreme_of(acc, line_mem[(r - m) % SLOTS][(c - 2 * m + l) % COLS_CAP]);
      end
      res.value = acc;
      res.row = COORD_W'(r - m);
      res.col = COORD_W'(c - m);
      res.tail = (r == h - 1 && c == w - 1);
      expected_morph.push_back(res);
    end
    if (c >= w - 1) begin
      pix_col = 0;
      pix_row = (r >= h - 1) ? 0 : r + 1;
    end else begin
      pix_col = c + 1;
    end
  endfunction

  // pixels still needed to bring the raster back to the top left corner
  function automatic int pixels_to_origin();
    int unsigned w, h, r, c;
    int n;
    w = dim_eff(shadow_cfg.frame_width, COLS_CAP);
    h = dim_eff(shadow_cfg.frame_height, ROWS_CAP);
    r = pix_row;
    c = pix_col;
    n = 0;
    while (r != 0 || c != 0) begin
      if (c >= w - 1) begin
        c = 0;
        r = (r >= h - 1) ? 0 : r + 1;
      end else begin
        c = c + 1;
      end
      n++;
    end
    return n;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic check_beat();
    morph_beat_t want;
    logic [PIX_W-1:0] got_value;
    logic [COORD_W-1:0] got_row, got_col;
    got_value = m_tdata[PIX_W-1:0];
    got_row = m_tdata[PIX_W +: COORD_W];
    got_col = m_tdata[PIX_W + COORD_W +: COORD_W];
    if (expected_morph.size() == 0) begin
      flag_mismatch($sformatf("result beat with none pending, tdata %h", m_tdata));
    end else begin
      want = expected_morph.pop_front();
      if (got_value !== want.value || got_row !== want.row || got_col !== want.col ||
          m_tlast !== want.tail)
        flag_mismatch($sformatf("got pix %h row %0d col %0d last %b, want %h %0d %0d %b",
                                got_value, got_row, got_col, m_tlast,
                                want.value, want.row, want.col, want.tail));
    end
  endtask

  // pixel sender
  always @(posedge clk) begin : pixel_driver
    if (rst) begin
      s_tvalid <= 1'b0;
      send_wait <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        absorb_pixel(s_tdata[PIX_W-1:0]);
        beats_in++;
      end
      if (!s_tvalid || s_tready) begin
        if (send_wait > 0) begin
          s_tvalid <= 1'b0;
          send_wait <= send_wait - 1;
        end else if (pixels_to_send.size() != 0) begin
          s_tvalid <= 1'b1;
          s_tdata <= IN_TDATA_W'(pixels_to_send.pop_front());
          if ($urandom_range(0, 29) == 0) send_burst = !send_burst;
          send_wait <= send_burst ? 0 : $urandom_range(0, 10);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result receiver and checker
  always @(posedge clk) begin : result_monitor
    int draw;
    if (rst) begin
      m_tready <= 1'b0;
      recv_wait <= 0;
      recv_hold <= 0;
    end else begin
      draw = recv_wait;
      if (m_tvalid && m_tready) begin
        check_beat();
        beats_out++;
        if ($urandom_range(0, 29) == 0) recv_burst = !recv_burst;
        draw = recv_burst ? 0 : $urandom_range(0, 10);
      end
      if (recv_hold > 0) begin
        m_tready <= 1'b0;
        recv_hold <= recv_hold - 1;
        recv_wait <= draw;
      end else if (holds_done != hold_requests) begin
        // long stall so the input side backs up
        holds_done <= holds_done + 1;
        recv_hold <= LONG_HOLD;
        m_tready <= 1'b0;
        recv_wait <= draw;
      end else if (draw > 0) begin
        m_tready <= 1'b0;
        recv_wait <= draw - 1;
      end else begin
        m_tready <= 1'b1;
        recv_wait <= 0;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int unsigned v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(v);
    case (idx)
      REG_OPERATION:    shadow_cfg.operation = v[0];
      REG_WINDOW_SHAPE: shadow_cfg.window_shape = v[0];
      REG_RADIUS:       shadow_cfg.radius = v[RAD_W-1:0];
      REG_FRAME_WIDTH:  shadow_cfg.frame_width = v[CFG_DIM_W-1:0];
      REG_FRAME_HEIGHT: shadow_cfg.frame_height = v[CFG_DIM_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic queue_pixel(input logic [PIX_W-1:0] px);
    pixels_to_send.push_back(px);
    pixels_queued++;
  endtask

  task automatic queue_random(input int n);
    int i;
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0: queue_pixel('0);
        1: queue_pixel('1);
        default: queue_pixel(PIX_W'($urandom_range(0, 255)));
      endcase
    end
  endtask

  // wait until the block has drained, then give trailing pixels time to clear the pipeline
  task automatic settle();
    do @(negedge clk);
    while (pixels_to_send.size() != 0 || s_tvalid || expected_morph.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    int unsigned m, w, h, total, split, random_start;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings, first row only, so nothing comes out
    queue_pixel(8'h00);
    queue_pixel(8'hFF);
    queue_pixel(8'h55);
    queue_pixel(8'hAA);
    settle();

    // zero sizes act as 1x1; the column counter is past the new width and wraps
    write_reg(REG_RADIUS, 0);
    write_reg(REG_FRAME_WIDTH, 0);
    write_reg(REG_FRAME_HEIGHT, 0);
    settings_used++;
    queue_pixel(8'h3C);
    queue_pixel(8'h00);
    queue_pixel(8'hFF);
    settle();

    // widest row and oversized height, then back to 1x1 mid-row
    write_reg(REG_OPERATION, OP_DILATE);
    write_reg(REG_FRAME_WIDTH, COLS_CAP);
    write_reg(REG_FRAME_HEIGHT, 4095);
    settings_used++;
    queue_pixel(8'h80);
    queue_pixel(8'h7F);
    queue_pixel(8'h01);
    queue_pixel(8'hFE);
    settle();
    write_reg(REG_FRAME_WIDTH, 1);
    write_reg(REG_FRAME_HEIGHT, 1);
    settings_used++;
    queue_pixel(8'h11);
    queue_pixel(8'hFF);
    queue_pixel(8'h00);
    settle();

    // 3x3 erosion over the cross: corners are lower but must not count
    write_reg(REG_OPERATION, OP_ERODE);
    write_reg(REG_WINDOW_SHAPE, SHAPE_CROSS);
    write_reg(REG_RADIUS, 1);
    write_reg(REG_FRAME_WIDTH, 3);
    write_reg(REG_FRAME_HEIGHT, 3);
    settings_used++;
    queue_pixel(8'h01);
    queue_pixel(8'h90);
    queue_pixel(8'h02);
    queue_pixel(8'h91);
    queue_pixel(8'h92);
    queue_pixel(8'h93);
    queue_pixel(8'h03);
    queue_pixel(8'h94);
    queue_pixel(8'h04);
    settle();

    // every pixel is a result; receiver stalls long enough for the input to back up
    write_reg(REG_OPERATION, OP_DILATE);
    write_reg(REG_WINDOW_SHAPE, SHAPE_SQUARE);
    write_reg(REG_RADIUS, 0);
    write_reg(REG_FRAME_WIDTH, 30);
    write_reg(REG_FRAME_HEIGHT, 2);
    settings_used++;
    hold_requests++;
    queue_random(60);
    settle();

    random_start = pixels_queued;
    while (pixels_queued - random_start < RANDOM_BEATS) begin
      m = $urandom_range(0, 3);
      w = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2 * m)
                                      : $urandom_range(2 * m + 1, 2 * m + 10);
      h = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2 * m)
                                      : $urandom_range(2 * m + 1, 2 * m + 5);
      write_reg(REG_OPERATION, $urandom_range(0, 1));
      write_reg(REG_WINDOW_SHAPE, $urandom_range(0, 1));
      write_reg(REG_RADIUS, m);
      write_reg(REG_FRAME_WIDTH, w);
      write_reg(REG_FRAME_HEIGHT, h);
      settings_used++;
      total = dim_eff(w, COLS_CAP) * dim_eff(h, ROWS_CAP);
      if (total > 1 && $urandom_range(0, 2) == 0) begin
        // change settings part way through the frame; width may only shrink
        split = $urandom_range(1, total - 1);
        queue_random(split);
        settle();
        write_reg(REG_OPERATION, $urandom_range(0, 1));
        write_reg(REG_WINDOW_SHAPE, $urandom_range(0, 1));
        write_reg(REG_RADIUS, $urandom_range(0, 3));
        write_reg(REG_FRAME_HEIGHT, $urandom_range(0, dim_eff(h, ROWS_CAP) + 3));
        write_reg(REG_FRAME_WIDTH, $urandom_range(0, dim_eff(w, COLS_CAP)));
        settings_used++;
        queue_random(pixels_to_origin());
      end else begin
        queue_random(total);
      end
      settle();
    end

    repeat (20) @(posedge clk);
    $display("covered %0d pixel beats in, %0d result beats out, %0d register settings",
             beats_in, beats_out, settings_used);
    $display("erode and dilate, cross and square, radius 0 to 3, odd sizes, mid-frame changes");
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/gmf_pkg.sv
design/gmf_front.sv
design/gmf_queue.sv
design/gmf_back.sv
design/grayscale_morphology_filter_top.sv
test/grayscale_morphology_filter_top_tb.sv
